>>> design/msr_pkg.sv
// shared constants of the modular square root block
`timescale 1ns / 1ps
package msr_pkg;
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONRES = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam int SEARCH_LIMIT = 4096;
  localparam int SEARCH_END = 2 + SEARCH_LIMIT;
  localparam int SEARCH_W = $clog2(SEARCH_END + 1);
endpackage

>>> design/msr_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module msr_mulmod #(
  parameter int WORD_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic [WORD_BITS-1:0] res
);
  import msr_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] xr;
  logic [WORD_BITS-1:0] yr;
  logic [CW-1:0]        cnt;
  logic                 run;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   sum_red;
  logic [WORD_BITS:0]   m_ext;

  assign m_ext = {1'b0, m};

  always_comb begin
    dbl = {acc, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum = dbl_red + (yr[WORD_BITS-1] ? {1'b0, xr} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
  end

  assign res = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(WORD_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr <= x;
      yr <= y;
    end else if (run) begin
      acc <= sum_red[WORD_BITS-1:0];
      yr <= {yr[WORD_BITS-2:0], 1'b0};
    end
  end
endmodule

>>> design/modular_square_root_core.sv
// top level: cipolla modular square root sequencer with apb register port
`timescale 1ns / 1ps
// Takes one word on start while busy is low and returns one result word
// (root, status) on a single-cycle done strobe that the receiver cannot stall.
// All products run on one bit-serial modular multiplier that works through
// a product in an issue step, WORD_BITS bit steps and a handoff, and the
// sequencer spends a control state per exponent bit; an Euler test costs up
// to 2*(WORD_BITS-1) products, each candidate of the non-residue search one
// square and one Euler test, and the final power up to 9*WORD_BITS products.
// Range flag, zero and modulus two are answered straight from idle without
// the multiplier; otherwise the time taken depends on how many search
// candidates are tried. prime_modulus sits at byte address 0 and may
// be written only while busy is low.
module modular_square_root_core #(
  parameter int WORD_BITS = 31
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [WORD_BITS-1:0]                         value,
  output logic                                         busy,
  output logic                                         done,
  output logic [WORD_BITS-1:0]                         root,
  output logic [msr_pkg::STATUS_W-1:0]                 status,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [((WORD_BITS > 32) ? 4 : 3)-1:0]        paddr,
  input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0]      pwdata,
  output logic [((WORD_BITS > 32) ? 64 : 32)-1:0]      prdata,
  output logic                                         pready
);
  import msr_pkg::*;

  localparam int DW = (WORD_BITS > 32) ? 64 : 32;
  localparam int PA_W = (WORD_BITS > 32) ? 4 : 3;
  localparam int BW = ((WORD_BITS > SEARCH_W) ? WORD_BITS : SEARCH_W) + 1;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PW = 5'd1;
  localparam logic [4:0] ST_PW_MUL = 5'd2;
  localparam logic [4:0] ST_PW_SQR = 5'd3;
  localparam logic [4:0] ST_SRCH = 5'd4;
  localparam logic [4:0] ST_SRCH_SQ = 5'd5;
  localparam logic [4:0] ST_EXT = 5'd6;
  localparam logic [4:0] ST_E0 = 5'd7;
  localparam logic [4:0] ST_E1 = 5'd8;
  localparam logic [4:0] ST_E2 = 5'd9;
  localparam logic [4:0] ST_E3 = 5'd10;
  localparam logic [4:0] ST_E4 = 5'd11;
  localparam logic [4:0] ST_E5 = 5'd12;
  localparam logic [4:0] ST_E6 = 5'd13;
  localparam logic [4:0] ST_E7 = 5'd14;
  localparam logic [4:0] ST_E8 = 5'd15;

  logic [WORD_BITS-1:0] prime_modulus;
  logic [4:0]           state;
  logic                 pend;
  logic                 ctx_w;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] w;
  logic [BW-1:0]        b;
  logic [WORD_BITS-1:0] pw_acc;
  logic [WORD_BITS-1:0] pw_base;
  logic [WORD_BITS-1:0] e;
  logic [WORD_BITS-1:0] r0;
  logic [WORD_BITS-1:0] r1;
  logic [WORD_BITS-1:0] v0;
  logic [WORD_BITS-1:0] v1;
  logic [WORD_BITS-1:0] m1;
  logic [WORD_BITS-1:0] m2;
  logic [WORD_BITS-1:0] s0;

  logic                 mul_start;
  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_x;
  logic [WORD_BITS-1:0] mul_y;
  logic [WORD_BITS-1:0] mul_res;
  logic                 mul_state;
  logic                 cfg_wr;
  logic [WORD_BITS-1:0] sub_w;
  logic [WORD_BITS:0]   p_inc;

  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] x,
                                                   input logic [WORD_BITS-1:0] y,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[WORD_BITS-1:0];
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PA_W-1] == 1'b0) ? DW'(prime_modulus) : '0;
  assign busy = (state != ST_IDLE);
  assign p_inc = {1'b0, prime_modulus} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus <= WORD_BITS'(64'h7FFF_FFFF);
    end else if (cfg_wr && paddr[PA_W-1] == 1'b0) begin
      prime_modulus <= pwdata[WORD_BITS-1:0];
    end
  end

  assign mul_state = (state == ST_PW_MUL) || (state == ST_PW_SQR) || (state == ST_SRCH_SQ) ||
                     (state >= ST_E0);
  assign mul_start = mul_state && !pend;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      ST_PW_MUL:  begin mul_x = pw_acc;  mul_y = pw_base; end
      ST_PW_SQR:  begin mul_x = pw_base; mul_y = pw_base; end
      ST_SRCH_SQ: begin mul_x = b[WORD_BITS-1:0]; mul_y = b[WORD_BITS-1:0]; end
      ST_E0:      begin mul_x = r0; mul_y = v0; end
      ST_E1:      begin mul_x = r1; mul_y = v1; end
      ST_E2:      begin mul_x = m2; mul_y = w; end
      ST_E3:      begin mul_x = r0; mul_y = v1; end
      ST_E4:      begin mul_x = r1; mul_y = v0; end
      ST_E5:      begin mul_x = v0; mul_y = v0; end
      ST_E6:      begin mul_x = v1; mul_y = v1; end
      ST_E7:      begin mul_x = m2; mul_y = w; end
      ST_E8:      begin mul_x = v0; mul_y = v1; end
      default:    begin mul_x = '0; mul_y = '0; end
    endcase
  end

  msr_mulmod #(.WORD_BITS(WORD_BITS)) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (prime_modulus),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign sub_w = (mul_res >= a) ? mul_res - a : WORD_BITS'({1'b0, mul_res} +
                 {1'b0, prime_modulus} - {1'b0, a});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend <= 1'b0;
      done <= 1'b0;
      ctx_w <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mul_start) pend <= 1'b1;
      if (mul_done) pend <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            a <= value;
            if (value >= prime_modulus) begin
              root <= '0; status <= STATUS_RANGE; done <= 1'b1;
            end else if (value == '0) begin
              root <= '0; status <= STATUS_OK; done <= 1'b1;
            end else if (prime_modulus == WORD_BITS'(2)) begin
              root <= value; status <= STATUS_OK; done <= 1'b1;
            end else begin
              pw_acc <= WORD_BITS'(1);
              pw_base <= value;
              e <= (prime_modulus - 1'b1) >> 1;
              ctx_w <= 1'b0;
              state <= ST_PW;
            end
          end
        end
        ST_PW: begin
          if (e == '0) begin
            if (!ctx_w) begin
              if (pw_acc != WORD_BITS'(1)) begin
                root <= '0; status <= STATUS_NONRES; done <= 1'b1;
                state <= ST_IDLE;
              end else begin
                b <= BW'(2);
                state <= ST_SRCH;
              end
            end else if (pw_acc != WORD_BITS'(1)) begin
              e <= p_inc[WORD_BITS:1];
              r0 <= WORD_BITS'(1);
              r1 <= '0;
              v0 <= b[WORD_BITS-1:0];
              v1 <= WORD_BITS'(1);
              state <= ST_EXT;
            end else begin
              b <= b + 1'b1;
              state <= ST_SRCH;
            end
          end else begin
            state <= e[0] ? ST_PW_MUL : ST_PW_SQR;
          end
        end
        ST_PW_MUL: begin
          if (mul_done) begin pw_acc <= mul_res; state <= ST_PW_SQR; end
        end
        ST_PW_SQR: begin
          if (mul_done) begin
            pw_base <= mul_res;
            e <= e >> 1;
            state <= ST_PW;
          end
        end
        ST_SRCH: begin
          if (b >= BW'(prime_modulus) || b >= BW'(SEARCH_END)) begin
            root <= '0; status <= STATUS_NONRES; done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_SRCH_SQ;
          end
        end
        ST_SRCH_SQ: begin
          if (mul_done) begin
            w <= sub_w;
            pw_base <= sub_w;
            pw_acc <= WORD_BITS'(1);
            e <= (prime_modulus - 1'b1) >> 1;
            ctx_w <= 1'b1;
            state <= ST_PW;
          end
        end
        ST_EXT: begin
          if (e == '0) begin
            root <= r0; status <= STATUS_OK; done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= e[0] ? ST_E0 : ST_E5;
          end
        end
        ST_E0: if (mul_done) begin m1 <= mul_res; state <= ST_E1; end
        ST_E1: if (mul_done) begin m2 <= mul_res; state <= ST_E2; end
        ST_E2: if (mul_done) begin
          s0 <= add_mod(m1, mul_res, prime_modulus);
          state <= ST_E3;
        end
        ST_E3: if (mul_done) begin m1 <= mul_res; state <= ST_E4; end
        ST_E4: if (mul_done) begin
          r1 <= add_mod(m1, mul_res, prime_modulus);
          r0 <= s0;
          state <= ST_E5;
        end
        ST_E5: if (mul_done) begin m1 <= mul_res; state <= ST_E6; end
        ST_E6: if (mul_done) begin m2 <= mul_res; state <= ST_E7; end
        ST_E7: if (mul_done) begin
          s0 <= add_mod(m1, mul_res, prime_modulus);
          state <= ST_E8;
        end
        ST_E8: if (mul_done) begin
          v1 <= add_mod(mul_res, mul_res, prime_modulus);
          v0 <= s0;
          e <= e >> 1;
          state <= ST_EXT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> verif/modular_square_root_core_tb.sv
// testbench for the modular square root core: directed and random words checked against a predictor
`timescale 1ns / 1ps
module modular_square_root_core_tb;
  import msr_pkg::*;

  localparam int WB = 31;
  localparam int WATCHDOG_LIMIT = 2000000;
  localparam logic [WB-1:0] ALL_ONES = {WB{1'b1}};
  localparam logic [2:0] ADDR_MODULUS = 3'd0;

  class root_scoreboard;
    longint unsigned modulus;
    logic [WB-1:0] root_q[$];
    logic [STATUS_W-1:0] status_q[$];
    int mismatches;
    int results;

    function new();
      modulus = 64'h7fffffff;
      mismatches = 0;
      results = 0;
    endfunction

    function longint unsigned mulm(longint unsigned x, longint unsigned y, longint unsigned m);
      return (x * y) % m;
    endfunction

    function longint unsigned powm(longint unsigned bs, longint unsigned e, longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      bs = bs % m;
      while (e != 0) begin
        if (e[0]) acc = mulm(acc, bs, m);
        bs = mulm(bs, bs, m);
        e = e >> 1;
      end
      return acc;
    endfunction

    function bit is_residue(longint unsigned x, longint unsigned m);
      return powm(x, (m - 1) >> 1, m) == 1;
    endfunction

    task automatic cipolla_root(input longint unsigned a, output logic [WB-1:0] r,
                                output logic [STATUS_W-1:0] st);
      longint unsigned p, b, w, e, r0, r1, v0, v1, t0, t1;
      bit found;
      p = modulus;
      r = '0;
      st = STATUS_OK;
      found = 0;
      w = 0;
      if (a >= p) begin
        st = STATUS_RANGE;
      end else if (a == 0) begin
        r = '0;
      end else if (p == 2) begin
        r = a[WB-1:0];
      end else if (!is_residue(a, p)) begin
        st = STATUS_NONRES;
      end else begin
        b = 2;
        while (b < p && b < SEARCH_END) begin
          w = (mulm(b, b, p) + p - a) % p;
          if (!is_residue(w, p)) begin
            found = 1;
            break;
          end
          b++;
        end
        if (!found) begin
          st = STATUS_NONRES;
        end else begin
          e = (p + 1) >> 1;
          r0 = 1; r1 = 0; v0 = b; v1 = 1;
          while (e != 0) begin
            if (e[0]) begin
              t0 = (mulm(r0, v0, p) + mulm(mulm(r1, v1, p), w, p)) % p;
              t1 = (mulm(r0, v1, p) + mulm(r1, v0, p)) % p;
              r0 = t0; r1 = t1;
            end
            t0 = (mulm(v0, v0, p) + mulm(mulm(v1, v1, p), w, p)) % p;
            t1 = (mulm(v0, v1, p) + mulm(v1, v0, p)) % p;
            v0 = t0; v1 = t1;
            e = e >> 1;
          end
          r = r0[WB-1:0];
        end
      end
    endtask

    task note_word(input logic [WB-1:0] v);
      logic [WB-1:0] r;
      logic [STATUS_W-1:0] st;
      cipolla_root(longint'(v), r, st);
      root_q.push_back(r);
      status_q.push_back(st);
    endtask

    task report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_word(input logic [WB-1:0] r, input logic [STATUS_W-1:0] st);
      logic [WB-1:0] er;
      logic [STATUS_W-1:0] es;
      results++;
      if (root_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word root=%0d status=%0d", r, st));
      end else begin
        er = root_q.pop_front();
        es = status_q.pop_front();
        if (r !== er) report_mismatch($sformatf("root %0d, expected %0d", r, er));
        if (st !== es) report_mismatch($sformatf("status %0d, expected %0d", st, es));
      end
    endtask
  endclass

  logic clk, rst, start, psel, penable, pwrite;
  logic [WB-1:0] value;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic busy, done, pready;
  logic [WB-1:0] root;
  logic [STATUS_W-1:0] status;
  logic [31:0] prdata;

  root_scoreboard sb;
  int words_sent;
  int quiet_cycles;
  bit calm;

  modular_square_root_core #(.WORD_BITS(WB)) dut (
    .clk(clk), .rst(rst), .start(start), .value(value), .busy(busy), .done(done),
    .root(root), .status(status), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_word(root, status);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task drain();
    while (sb.root_q.size() != 0) @(posedge clk);
  endtask

  task write_modulus(input logic [31:0] d);
    drain();
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_MODULUS; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.modulus = longint'(d[WB-1:0]);
    psel <= 1; penable <= 0; pwrite <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata[WB-1:0] !== d[WB-1:0])
      sb.report_mismatch($sformatf("modulus reads %0d, wrote %0d", prdata, d[WB-1:0]));
    psel <= 0; penable <= 0;
  endtask

  task send_word(input logic [WB-1:0] v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(v);
    words_sent++;
  endtask

  task finish_burst();
    start <= 0;
    @(posedge clk);
  endtask

  function logic [WB-1:0] pick_value(longint unsigned p);
    int sel;
    sel = $urandom_range(0, 19);
    if (p == 0 || sel < 3) return WB'($urandom());
    if (sel == 3) return ALL_ONES;
    if (sel == 4) return p[WB-1:0];
    if (sel == 5) return p[WB-1:0] - 1'b1;
    if (sel == 6) return '0;
    return WB'({$urandom(), $urandom()} % p);
  endfunction

  initial begin
    longint unsigned moduli[14];
    longint unsigned p;
    int idx, n, phases;
    moduli = '{2, 3, 5, 7, 13, 9, 15, 97, 65537, 1000003,
               2147483629, 2147483647, 0, 1};
    sb = new();
    words_sent = 0;
    calm = 0;
    phases = 0;
    rst = 1; start = 0; value = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset modulus, extremes and small squares, then moduli 2, 0, all ones, 13 and 1
    send_word('0); send_word(WB'(1)); send_word(WB'(4)); send_word(WB'(2));
    send_word(ALL_ONES - 1'b1); send_word(ALL_ONES); send_word(WB'(32'h40000000));
    finish_burst();
    write_modulus(2);
    send_word(WB'(0)); send_word(WB'(1)); send_word(WB'(2)); send_word(ALL_ONES);
    finish_burst();
    write_modulus(0);
    send_word(WB'(0)); send_word(ALL_ONES); send_word(WB'(5));
    finish_burst();
    write_modulus(32'hffffffff);
    send_word(ALL_ONES); send_word(ALL_ONES - 1'b1);
    finish_burst();
    write_modulus(13);
    send_word(WB'(2)); send_word(WB'(3)); send_word(WB'(12)); send_word(WB'(10));
    finish_burst();
    write_modulus(1);
    send_word(WB'(0)); send_word(WB'(1));
    finish_burst();

    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 11);
      idx = (ph == 11) ? $urandom_range(0, 7) : $urandom_range(0, 13);
      p = moduli[idx];
      write_modulus(32'(p));
      phases++;
      n = (p > 1000000) ? 3 : 10;
      for (int i = 0; i < n; i++) send_word(pick_value(p));
      finish_burst();
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d words sent over %0d random modulus phases plus directed cases,",
             words_sent, phases);
    $display("%0d result words checked", sb.results);
    if (sb.mismatches == 0 && sb.root_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
